[sv/dlkm_pkg.sv]
// Shared types and constants for the dual LFSR keystream masker.
`timescale 1ns / 1ps

package dlkm_pkg;

   localparam int SHORT_LEN = 35;
   localparam int LONG_LEN  = 135;
   localparam int SHORT_TAP = 2;
   localparam int LONG_TAP  = 22;
   localparam int BYTE_BITS = 8;
   localparam int TOP_BITS  = LONG_LEN - 128;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [SHORT_LEN-1:0] SEED_SHORT_RESET    = 35'h1A3F5C9AB;
   localparam logic [63:0]          SEED_LONG_LOW_RESET = 64'hAAFEBBECFEBAAFCA;
   localparam logic [63:0]          SEED_LONG_MID_RESET = 64'h0000000ABFCBBAEA;
   localparam logic [TOP_BITS-1:0]  SEED_LONG_TOP_RESET = '0;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SEED_SHORT    = 3'd0,
      CSR_SEED_LONG_LOW = 3'd1,
      CSR_SEED_LONG_MID = 3'd2,
      CSR_SEED_LONG_TOP = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [LONG_LEN-1:0]  long_reg;
      logic [SHORT_LEN-1:0] short_reg;
   } lfsr_state_type;

endpackage

[sv/dlkm_step_cell.sv]
// One LFSR step cell: advances both registers once and yields one keystream bit.
`timescale 1ns / 1ps

module dlkm_step_cell (
   input  dlkm_pkg::lfsr_state_type state_i,
   output dlkm_pkg::lfsr_state_type state_o,
   output logic                     key_bit_o
);

   logic short_fb;
   logic long_fb;

   assign short_fb = state_i.short_reg[0] ^ state_i.short_reg[dlkm_pkg::SHORT_TAP];
   assign long_fb  = state_i.long_reg[0] ^ state_i.long_reg[dlkm_pkg::LONG_TAP];

   // Shift right, feedback enters at the top.
   assign state_o.short_reg = {short_fb, state_i.short_reg[dlkm_pkg::SHORT_LEN-1:1]};
   assign state_o.long_reg  = {long_fb, state_i.long_reg[dlkm_pkg::LONG_LEN-1:1]};
   assign key_bit_o         = short_fb ^ long_fb;

endmodule

[sv/dlkm_seed_regs.sv]
// Seed configuration registers written through the csr port.
`timescale 1ns / 1ps

module dlkm_seed_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [dlkm_pkg::CSR_INDEX_BITS-1:0] wr_index,
   input  logic [dlkm_pkg::CSR_DATA_BITS-1:0]  wr_data,
   output dlkm_pkg::lfsr_state_type            seed_o
);

   logic [dlkm_pkg::SHORT_LEN-1:0] seed_short_ff;
   logic [63:0]                    seed_low_ff;
   logic [63:0]                    seed_mid_ff;
   logic [dlkm_pkg::TOP_BITS-1:0]  seed_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_short_ff <= dlkm_pkg::SEED_SHORT_RESET;
         seed_low_ff   <= dlkm_pkg::SEED_LONG_LOW_RESET;
         seed_mid_ff   <= dlkm_pkg::SEED_LONG_MID_RESET;
         seed_top_ff   <= dlkm_pkg::SEED_LONG_TOP_RESET;
      end else if (wr_en) begin
         case (wr_index)
            dlkm_pkg::CSR_SEED_SHORT: begin
               seed_short_ff <= wr_data[dlkm_pkg::SHORT_LEN-1:0];
            end
            dlkm_pkg::CSR_SEED_LONG_LOW: begin
               seed_low_ff <= wr_data;
            end
            dlkm_pkg::CSR_SEED_LONG_MID: begin
               seed_mid_ff <= wr_data;
            end
            dlkm_pkg::CSR_SEED_LONG_TOP: begin
               seed_top_ff <= wr_data[dlkm_pkg::TOP_BITS-1:0];
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   assign seed_o.short_reg = seed_short_ff;
   assign seed_o.long_reg  = {seed_top_ff, seed_mid_ff, seed_low_ff};

endmodule

[sv/dual_lfsr_keystream_masker_core.sv]
// Top level of the dual LFSR keystream masker.
`timescale 1ns / 1ps

// Usage:
//   req_ channel carries one request per byte: req_data_byte and req_restart.
//   A request is taken at a clock edge with req_valid high and req_stall low.
//   rsp_ channel returns rsp_masked_byte = req_data_byte XOR eight keystream
//   bits (first bit in the LSB); the receiver holds rsp_stall to pause it.
//   csr_ channel writes seeds: index 0 short seed, 1..3 long seed low, mid,
//   top. csr_ready is always high; indexes above 3 are ignored. New seeds
//   take effect at the next restart; reset loads the default seeds.
//   The result is registered and appears in the cycle after its request is taken.
//   Throughput: one byte per cycle unless a result waits under rsp_stall;
//   a row of eight step cells advances both registers eight steps at once.
//   The output register frees in the same cycle it is taken, so requests
//   keep flowing back to back while the receiver takes results.
//   Stall: while a result waits under rsp_stall, req_stall is raised and the
//   LFSR state holds.
//   Reset: seeds return to their defaults, both LFSRs load them, and the
//   output register empties.
//   restart=1 reloads both LFSRs from the current seeds before this byte.

module dual_lfsr_keystream_masker_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_masked_byte,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dlkm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dlkm_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   dlkm_pkg::lfsr_state_type seed;
   dlkm_pkg::lfsr_state_type state_ff;
   dlkm_pkg::lfsr_state_type state_in;
   dlkm_pkg::lfsr_state_type chain [dlkm_pkg::BYTE_BITS+1];
   logic [dlkm_pkg::BYTE_BITS-1:0] key_byte;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       accept;

   assign csr_ready = 1'b1;

   dlkm_seed_regs u_seed_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .seed_o   (seed)
   );

   // Hold a request back only while a result waits under stall.
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Restart starts the cell row from the seeds instead of the running state.
   assign chain[0] = req_restart ? seed : state_ff;

   for (genvar i = 0; i < dlkm_pkg::BYTE_BITS; i++) begin : g_cells
      dlkm_step_cell u_cell (
         .state_i   (chain[i]),
         .state_o   (chain[i+1]),
         .key_bit_o (key_byte[i])
      );
   end

   // Advance the LFSRs only on a taken request.
   assign state_in     = accept ? chain[dlkm_pkg::BYTE_BITS] : state_ff;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= seed_reset_value();
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff <= req_data_byte ^ key_byte;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_masked_byte = rsp_byte_ff;

   // Default seeds, loaded into the LFSRs at reset.
   function automatic dlkm_pkg::lfsr_state_type seed_reset_value();
      dlkm_pkg::lfsr_state_type v;
      v.short_reg = dlkm_pkg::SEED_SHORT_RESET;
      v.long_reg  = {dlkm_pkg::SEED_LONG_TOP_RESET, dlkm_pkg::SEED_LONG_MID_RESET,
                     dlkm_pkg::SEED_LONG_LOW_RESET};
      return v;
   endfunction

endmodule

[tb/tb.sv]
// Self-checking testbench for the dual LFSR keystream masker core.
`timescale 1ns / 1ps

module tb;
   import dlkm_pkg::*;

   // Run control
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SEGMENTS      = 16;
   localparam int SEG_REQUESTS  = 100;
   localparam int SETTLE_CYCLES = 4;

   // Indexes outside the seed map; writes there must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = 3'd7;

   typedef enum logic {ROW_REQUEST, ROW_SEED_WRITE} row_kind_type;

   typedef enum int {
      SEEDS_RANDOM, SEEDS_ZERO, SEEDS_ONES, SHORT_ZERO, LONG_ZERO, SEEDS_PARTIAL
   } seed_plan_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  value;
      logic [7:0]                data;
      logic                      restart;
      logic                      typed;
      logic [7:0]                want;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_data_byte = '0;
   logic                      req_restart = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_masked_byte;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // Predictor state: seeds as written and the two running registers
   logic [SHORT_LEN-1:0] seed_short_q;
   logic [63:0]          seed_low_q;
   logic [63:0]          seed_mid_q;
   logic [TOP_BITS-1:0]  seed_top_q;
   logic [SHORT_LEN-1:0] short_lfsr;
   logic [LONG_LEN-1:0]  long_lfsr;

   logic [7:0]   masked_q[$];
   stim_row_type stim_rows[$];
   csr_index_type seed_regs[4] = '{CSR_SEED_SHORT, CSR_SEED_LONG_LOW,
                                   CSR_SEED_LONG_MID, CSR_SEED_LONG_TOP};

   int   mismatch_count = 0;
   int   accepted_reqs  = 0;
   int   seed_writes    = 0;
   int   cycle_count    = 0;
   int   send_idle_pct  = 0;
   int   recv_idle_pct  = 0;
   int   holds_asked    = 0;
   int   holds_done     = 0;
   int   hold_left      = 0;
   logic row_typed      = 1'b0;
   logic [7:0] row_want = '0;

   dual_lfsr_keystream_masker_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_masked_byte (rsp_masked_byte),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void load_lfsrs();
      short_lfsr = seed_short_q;
      long_lfsr  = {seed_top_q, seed_mid_q, seed_low_q};
   endfunction

   // Run eight steps of both registers; keystream bit i is the XOR of the
   // feedback bits of step i, first step in the LSB.
   function automatic logic [7:0] next_keystream();
      logic [7:0] ks;
      logic       fb_short;
      logic       fb_long;
      ks = '0;
      for (int i = 0; i < BYTE_BITS; i++) begin
         fb_short   = short_lfsr[0] ^ short_lfsr[SHORT_TAP];
         fb_long    = long_lfsr[0] ^ long_lfsr[LONG_TAP];
         short_lfsr = {fb_short, short_lfsr[SHORT_LEN-1:1]};
         long_lfsr  = {fb_long, long_lfsr[LONG_LEN-1:1]};
         ks[i]      = fb_short ^ fb_long;
      end
      return ks;
   endfunction

   // Seed writes only land in the seed copies; running registers hold
   function automatic void apply_seed_write(logic [CSR_INDEX_BITS-1:0] idx,
                                            logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         CSR_SEED_SHORT:    seed_short_q = value[SHORT_LEN-1:0];
         CSR_SEED_LONG_LOW: seed_low_q   = value;
         CSR_SEED_LONG_MID: seed_mid_q   = value;
         CSR_SEED_LONG_TOP: seed_top_q   = value[TOP_BITS-1:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("ERROR at %0t: %s, got %02h, want %02h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Sample both channels at the rising edge; predict on request accept
   always @(posedge clock) begin : monitor
      logic [7:0] want;
      if (reset) begin
         seed_short_q = SEED_SHORT_RESET;
         seed_low_q   = SEED_LONG_LOW_RESET;
         seed_mid_q   = SEED_LONG_MID_RESET;
         seed_top_q   = SEED_LONG_TOP_RESET;
         load_lfsrs();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (masked_q.size() == 0) begin
               report_mismatch("result with no request pending", rsp_masked_byte, 'x);
            end else begin
               want = masked_q.pop_front();
               if (rsp_masked_byte !== want)
                  report_mismatch("wrong masked byte", rsp_masked_byte, want);
            end
         end
         if (req_valid && !req_stall) begin
            if (req_restart)
               load_lfsrs();
            want = req_data_byte ^ next_keystream();
            if (row_typed)
               want = row_want;
            masked_q.push_back(want);
            accepted_reqs++;
         end
         if (csr_valid && csr_ready) begin
            apply_seed_write(csr_index, csr_data);
            seed_writes++;
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (holds_asked != holds_done) begin
         holds_done = holds_asked;
         hold_left  = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("dual_lfsr_keystream_masker_core: mismatch");
         $finish;
      end
   end

   // Offer one request; hold the payload until the monitor counts it taken
   task automatic send_request(input logic [7:0] data, input logic restart,
                               input logic typed, input logic [7:0] want);
      int target;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      row_typed     = typed;
      row_want      = want;
      target        = accepted_reqs + 1;
      req_valid     <= 1'b1;
      req_data_byte <= data;
      req_restart   <= restart;
      do @(negedge clock); while (accepted_reqs < target);
   endtask

   // Caller makes sure the block is idle; valid stays up for back-to-back writes
   task automatic write_seed(input logic [CSR_INDEX_BITS-1:0] idx,
                             input logic [CSR_DATA_BITS-1:0] value);
      int target;
      target    = seed_writes + 1;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (seed_writes < target);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (masked_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_seeds(input seed_plan_type plan);
      logic [CSR_DATA_BITS-1:0] value;
      foreach (seed_regs[k]) begin
         case (plan)
            SEEDS_ZERO: value = '0;
            SEEDS_ONES: value = '1;
            SHORT_ZERO: value = (seed_regs[k] == CSR_SEED_SHORT) ? '0 : {$urandom, $urandom};
            LONG_ZERO:  value = (seed_regs[k] == CSR_SEED_SHORT) ? {$urandom, $urandom} : '0;
            default:    value = {$urandom, $urandom};
         endcase
         if (plan != SEEDS_PARTIAL || $urandom_range(1))
            write_seed(seed_regs[k], value);
      end
      if (plan == SEEDS_PARTIAL)
         write_seed(CSR_INDEX_BITS'($urandom_range(CSR_UNUSED_HI, CSR_UNUSED_LO)),
                    {$urandom, $urandom});
   endtask

   function automatic void add_request(logic [7:0] data, logic restart, logic typed,
                                       logic [7:0] want);
      stim_rows.push_back('{ROW_REQUEST, '0, '0, data, restart, typed, want});
   endfunction

   function automatic void add_seed_write(logic [CSR_INDEX_BITS-1:0] idx,
                                          logic [CSR_DATA_BITS-1:0] value);
      stim_rows.push_back('{ROW_SEED_WRITE, idx, value, '0, 1'b0, 1'b0, '0});
   endfunction

   initial begin
      stim_row_type  row;
      logic          prev_write;
      seed_plan_type plan;

      // Default seeds straight after reset, then a restart onto the same seeds
      add_request(8'h00, 1'b0, 1'b0, '0);
      add_request(8'hFF, 1'b0, 1'b0, '0);
      add_request(8'h00, 1'b1, 1'b0, '0);
      add_request(8'h80, 1'b0, 1'b0, '0);
      add_request(8'h01, 1'b0, 1'b0, '0);
      // Zero both seeds; writes to unused indexes must not land anywhere
      foreach (seed_regs[k])
         add_seed_write(seed_regs[k], '0);
      add_seed_write(CSR_UNUSED_LO, '1);
      add_seed_write(CSR_UNUSED_HI, 64'hDEAD_BEEF_0BAD_F00D);
      // Running registers keep going until the restart
      add_request(8'h5A, 1'b0, 1'b0, '0);
      // Zero registers give a zero keystream, so data passes through
      add_request(8'h00, 1'b1, 1'b1, 8'h00);
      add_request(8'hFF, 1'b0, 1'b1, 8'hFF);
      add_request(8'hA5, 1'b0, 1'b1, 8'hA5);
      // All-ones seeds: excess bits of the short and top words are dropped
      foreach (seed_regs[k])
         add_seed_write(seed_regs[k], '1);
      add_request(8'h3C, 1'b0, 1'b1, 8'h3C);
      add_request(8'h00, 1'b1, 1'b0, '0);
      add_request(8'hFF, 1'b0, 1'b0, '0);
      add_request(8'h7E, 1'b0, 1'b0, '0);
      // Short register zero, long register all ones
      add_seed_write(CSR_SEED_SHORT, '0);
      add_request(8'h00, 1'b1, 1'b0, '0);
      add_request(8'hFF, 1'b0, 1'b0, '0);
      add_request(8'hC3, 1'b0, 1'b0, '0);

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      prev_write = 1'b0;
      foreach (stim_rows[r]) begin
         row = stim_rows[r];
         if (row.kind == ROW_SEED_WRITE) begin
            if (!prev_write)
               wait_idle();
            write_seed(row.index, row.value);
         end else begin
            send_request(row.data, row.restart, row.typed, row.want);
         end
         prev_write = (row.kind == ROW_SEED_WRITE);
      end

      // Random segments: each drains, reseeds, and runs under one idle profile
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 6) begin
            send_idle_pct = 8;
            recv_idle_pct = 87;
         end else if (seg < 12) begin
            send_idle_pct = 87;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         wait_idle();
         plan = seed_plan_type'($urandom_range(SEEDS_PARTIAL, SEEDS_RANDOM));
         program_seeds(plan);
         for (int n = 0; n < SEG_REQUESTS; n++) begin
            // Stall the receiver for a long stretch while requests keep coming
            if (seg >= 12 && seg % 2 == 0 && n == 20)
               holds_asked++;
            send_request(8'($urandom_range(255)),
                         (n == 0) ? 1'($urandom_range(1)) : ($urandom_range(11) == 0),
                         1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0 && masked_q.size() == 0) begin
         $display("dual_lfsr_keystream_masker_core: match");
      end else begin
         $display("dual_lfsr_keystream_masker_core: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
sv/dlkm_pkg.sv
sv/dlkm_step_cell.sv
sv/dlkm_seed_regs.sv
sv/dual_lfsr_keystream_masker_core.sv
tb/tb.sv
